// ===== rtl/lcm_pair_counter_assert.svh =====
// Assertion macros for the lcm_pair_counter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LCM_PAIR_COUNTER_ASSERT_SVH
`define LCM_PAIR_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LPC_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lcm_pair_counter assertion failed");
// next-cycle implication
`define LPC_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lcm_pair_counter assertion failed");
`else
`define LPC_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define LPC_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lpc_pkg.sv =====
// Shared constants for the lcm pair counter.
// No dependencies; imported by lpc_div and lcm_pair_counter.
package lpc_pkg;
	// default width of n
	localparam int VALUE_BITS_DEF = 48;
	// result width
	localparam int COUNT_BITS     = 32;
	// running product is kept modulo 2^(COUNT_BITS+1): enough for prod/2 + 1
	localparam int PROD_BITS      = COUNT_BITS + 1;
	// exponent counter, holds up to 127
	localparam int EXP_BITS       = 7;
	// factor (2e+1)
	localparam int FACT_BITS      = EXP_BITS + 1;
endpackage

// ===== rtl/lpc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by every trial division.
// Depends on lpc_pkg.
module lpc_div import lpc_pkg::*; #(
	parameter int WIDTH = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quot,
	output logic [WIDTH-1:0] rem
);
	localparam int CW = $clog2(WIDTH + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dsr_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_nx;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial  = {rem_q, quo_q[WIDTH-1]};
		ge     = (trial >= {1'b0, dsr_q});
		diff   = trial - {1'b0, dsr_q};
		rem_nx = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/lcm_pair_counter.sv =====
// Top level of the lcm pair counter: sequencer, product register, result port.
// Depends on lpc_pkg, lpc_div and lcm_pair_counter_assert.svh.
//
// Usage: drive n and pulse start while busy is low; the item is taken at that
// edge. busy stays high while n is factored. The result appears on pair_count
// with done high for exactly one cycle; the receiver cannot stall it, so it
// must capture the value in that cycle. busy is low again in the done cycle,
// and a new start may be given there.
// n = 0 answers 0 in the cycle after start without going busy.
// Sequence: the factor 2 is stripped with one division per exponent plus one,
// then each odd candidate d with d*d <= rest costs one division, plus one per
// extra power of d found. Each division passes S_LAUNCH, which starts the
// shared restoring divider, and S_DIV, which waits for its done; a candidate
// that does not divide adds the product update in S_MUL and the bound check
// in S_CHECK. Worst case (a large prime near 2^48) runs about 8.4 million
// candidates.
// Reset (arst_n low) aborts any item in flight and returns to idle.
`include "lcm_pair_counter_assert.svh"
module lcm_pair_counter import lpc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] n,
	output logic                  done,
	output logic [COUNT_BITS-1:0] pair_count
);
	localparam int VB = VALUE_BITS;
	localparam int SW = VALUE_BITS + 2;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LAUNCH = 6'b000010,
		S_DIV    = 6'b000100,
		S_MUL    = 6'b001000,
		S_CHECK  = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [VB-1:0]         rest_q;
	logic [VB-1:0]         d_q;
	logic [SW-1:0]         sq_q;
	logic [EXP_BITS-1:0]   e_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [COUNT_BITS-1:0] pair_count_q;

	logic          div_start;
	logic          div_done;
	logic [VB-1:0] div_quot;
	logic [VB-1:0] div_rem;

	logic                          accept;
	logic                          is_two;
	logic [FACT_BITS-1:0]          factor;
	logic [PROD_BITS+FACT_BITS-1:0] mul_full;
	logic [PROD_BITS-1:0]          prod_fin;
	logic [COUNT_BITS-1:0]         count_fin;

	assign accept    = start && (state_q == S_IDLE);
	assign div_start = (state_q == S_LAUNCH);
	assign is_two    = (d_q == VB'(2));

	// product update terms
	always_comb begin
		factor   = {e_q, 1'b1};
		mul_full = {{FACT_BITS{1'b0}}, prod_q} * {{PROD_BITS{1'b0}}, factor};
		prod_fin = (rest_q > VB'(1)) ? (prod_q + {prod_q[PROD_BITS-2:0], 1'b0}) : prod_q;
		count_fin = prod_fin[PROD_BITS-1:1] + COUNT_BITS'(1);
	end

	lpc_div #(.WIDTH(VB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rest_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (n == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_LAUNCH;
						end
					end
				end
				S_LAUNCH: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= (div_rem == '0) ? S_LAUNCH : S_MUL;
					end
				end
				S_MUL: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= (sq_q <= {2'b00, rest_q}) ? S_LAUNCH : S_FIN;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// factoring datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rest_q <= n;
				d_q    <= VB'(2);
				sq_q   <= SW'(4);
				e_q    <= '0;
				prod_q <= PROD_BITS'(1);
				if (accept) begin
					pair_count_q <= '0;
				end
			end
			S_DIV: begin
				if (div_done && (div_rem == '0)) begin
					rest_q <= div_quot;
					e_q    <= e_q + EXP_BITS'(1);
				end
			end
			S_MUL: begin
				prod_q <= mul_full[PROD_BITS-1:0];
				e_q    <= '0;
				// next candidate: 3 after 2, then odd steps; (d+2)^2 = d^2 + 4d + 4
				if (is_two) begin
					d_q  <= VB'(3);
					sq_q <= SW'(9);
				end else begin
					d_q  <= d_q + VB'(2);
					sq_q <= sq_q + {d_q, 2'b00} + SW'(4);
				end
			end
			S_FIN: pair_count_q <= count_fin;
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign pair_count = pair_count_q;

	// checks
	`LPC_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`LPC_ASSERT_NXT(a_accept_busy_or_done, clk, arst_n, accept, busy || done_q)
	`LPC_ASSERT_NXT(a_strip_updates_rest, clk, arst_n,
		(state_q == S_DIV) && div_done && (div_rem == '0), rest_q == $past(div_quot))
endmodule

// ===== test/lcm_pair_counter_check.sv =====
`timescale 1ns / 1ps
// Checker for lcm_pair_counter: watches the start/busy and done channels.
// Predicts each pair count by trial division and compares it. Depends on lpc_pkg.
module lcm_pair_counter_check import lpc_pkg::*; #(
	parameter int VB = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [VB-1:0]         n,
	input  logic                  done,
	input  logic [COUNT_BITS-1:0] pair_count,
	output int                    fail_count,
	output int                    open_count,
	output int                    item_count,
	output int                    result_count
);
	typedef struct {
		logic [VB-1:0]         value;
		logic [COUNT_BITS-1:0] count;
	} due_count_t;

	due_count_t counts_due [$];
	int fails_q   = 0;
	int open_q    = 0;
	int items_q   = 0;
	int results_q = 0;

	assign fail_count   = fails_q;
	assign open_count   = open_q;
	assign item_count   = items_q;
	assign result_count = results_q;

	// unordered pairs (i <= j) with lcm(i, j) == value, low COUNT_BITS bits
	function automatic logic [COUNT_BITS-1:0] lcm_pairs_of(input logic [VB-1:0] value);
		longint unsigned rest, prod, expo, cand, total;
		if (value == '0)
			return '0;
		rest = value;
		prod = 1;
		// factor 2 first
		expo = 0;
		while (rest % 2 == 0) begin
			rest = rest / 2;
			expo++;
		end
		prod = prod * (2 * expo + 1);
		// odd candidates while cand^2 <= rest
		cand = 3;
		while (cand <= rest / cand) begin
			expo = 0;
			while (rest % cand == 0) begin
				rest = rest / cand;
				expo++;
			end
			prod = prod * (2 * expo + 1);
			cand += 2;
		end
		// leftover cofactor is one prime
		if (rest > 1)
			prod = prod * 3;
		total = prod / 2 + 1;
		return total[COUNT_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fails_q++;
	endtask

	// results first, so a done and a new start on one edge stay in order
	always @(posedge clk) begin
		due_count_t head;
		if (arst_n) begin
			if (done) begin
				results_q++;
				if (counts_due.size() == 0) begin
					report_mismatch($sformatf("pair_count %0d with no item outstanding",
						pair_count));
				end else begin
					head = counts_due.pop_front();
					if (pair_count !== head.count)
						report_mismatch($sformatf("n=%0d: pair_count %0d, predicted %0d",
							head.value, pair_count, head.count));
				end
			end
			if (start && !busy) begin
				items_q++;
				head.value = n;
				head.count = lcm_pairs_of(n);
				counts_due = {counts_due, head};
			end
			open_q = counts_due.size();
		end
	end
endmodule

// ===== test/lcm_pair_counter_test.sv =====
`timescale 1ns / 1ps
// Top of the lcm_pair_counter testbench: clock, reset, stimulus and verdict.
// Depends on lpc_pkg, the lcm_pair_counter RTL and lcm_pair_counter_check.
module lcm_pair_counter_test;
	import lpc_pkg::*;

	localparam int VB           = VALUE_BITS_DEF;
	localparam int RANDOM_ITEMS = 100;
	localparam int TAIL_CYCLES  = 200;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start  = 1'b0;
	logic [VB-1:0]         n      = '0;
	logic                  busy;
	logic                  done;
	logic [COUNT_BITS-1:0] pair_count;
	int                    fail_count, open_count, item_count, result_count;

	logic [VB-1:0] directed_values [$];
	int            burst_left = 0;

	lcm_pair_counter #(.VALUE_BITS(VB)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.n         (n),
		.done      (done),
		.pair_count(pair_count)
	);

	lcm_pair_counter_check #(.VB(VB)) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.n           (n),
		.done        (done),
		.pair_count  (pair_count),
		.fail_count  (fail_count),
		.open_count  (open_count),
		.item_count  (item_count),
		.result_count(result_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, far above the slowest run this test drives
	initial begin
		#200_000_000;
		$display("Mismatches found");
		$finish;
	end

	// idle cycles before a start: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 4);
		if (roll < 97)
			return $urandom_range(5, 40);
		return $urandom_range(100, 600);
	endfunction

	// values kept cheap to factor: small noise, shifted odd values,
	// and products of small odd factors with an optional odd cofactor
	function automatic logic [VB-1:0] random_value();
		longint unsigned lim, acc, fac;
		int mode, reps, pw;
		lim = (64'd1 << VB) - 64'd1;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			acc = ($urandom_range(0, 30) == 0) ? 0 : $urandom_range(0, 65535);
		end else if (mode == 1) begin
			// odd value slid up to the top bit
			acc = $urandom_range(0, 32767) * 2 + 1;
			while (acc <= (lim >> 1))
				acc = acc << 1;
		end else begin
			acc = 64'd1 << (($urandom_range(0, 7) == 0) ? $urandom_range(21, VB - 1)
				: $urandom_range(0, 20));
			reps = $urandom_range(1, 8);
			for (int k = 0; k < reps; k++) begin
				fac = $urandom_range(1, 23) * 2 + 1;
				pw = $urandom_range(1, 4);
				for (int p = 0; p < pw; p++)
					if (acc <= lim / fac)
						acc = acc * fac;
			end
			if ($urandom_range(0, 1) == 1) begin
				fac = $urandom_range(1, 2047) * 2 + 1;
				if (acc <= lim / fac)
					acc = acc * fac;
			end
		end
		return acc[VB-1:0];
	endfunction

	// present one value and hold it until the edge that takes it
	task automatic send_value(input logic [VB-1:0] value);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 19) == 0)
				burst_left = $urandom_range(5, 20);
		end
		if (gap > 0) begin
			start <= 1'b0;
			// sometimes let the block go idle before the gap counts
			if ($urandom_range(0, 3) == 0) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		n     <= value;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		// zero, one, tiny values, prime squares and products, top bit,
		// all ones and alternating bits, deep powers, many distinct primes
		directed_values = '{
			48'd0, 48'd1, 48'd2, 48'd3, 48'd4, 48'd9, 48'd12, 48'd15, 48'd256,
			48'd60491, 48'd63001, 48'd65521, 48'd720720,
			48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
			48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
			48'd205891132094649, 48'd237463620313920, 48'd281410552201216
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_values[i])
			send_value(directed_values[i]);
		repeat (RANDOM_ITEMS)
			send_value(random_value());
		start <= 1'b0;
		// drain, then watch for stray results
		@(negedge clk);
		while (open_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d values (zero, one, extremes, smooth and shifted products)",
			item_count);
		$display("Checked %0d pair counts, %0d failures", result_count, fail_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpc_pkg.sv
rtl/lpc_div.sv
rtl/lcm_pair_counter.sv
test/lcm_pair_counter_check.sv
test/lcm_pair_counter_test.sv
